### design/ldva_pkg.sv
// Shared types and constants for the linear distance volume attenuator.
`default_nettype none
package ldva_pkg;

  localparam int RAD_W    = 24;  // radius width, Q16.8
  localparam int BASE_W   = 15;  // base volume, Q7.8
  localparam int MULT_W   = 16;  // multiplier, Q4.12
  localparam int VOL_W    = 19;  // result volume, Q11.8
  localparam int PEAK_W   = BASE_W + MULT_W;
  localparam int LEG_W    = 26;  // clamped leg magnitude
  localparam int SQ_W     = 2 * RAD_W;  // distance squared in the audible range
  localparam int ROOT_W   = RAD_W;
  localparam int FRAC_SH  = 12;  // multiplier fraction bits
  localparam int PROD_W   = PEAK_W + RAD_W;
  localparam int OUT_W    = 24;  // result tdata, padded to bytes
  localparam int ZONE_W   = 2;

  // config register indexes
  localparam logic CFG_LIS_X = 1'b0;
  localparam logic CFG_LIS_Y = 1'b1;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_SILENT = 2'd0,
    ZONE_FULL   = 2'd1,
    ZONE_FALL   = 2'd2,
    ZONE_ZERO   = 2'd3
  } zone_t;

  // Per-request data that rides along the root and divide pipes.
  typedef struct packed {
    zone_t              zone;
    logic [PEAK_W-1:0]  peak;
    logic [RAD_W-1:0]   hear;
    logic [RAD_W-1:0]   scope;
  } ldva_side_t;

endpackage
`default_nettype wire

### design/ldva_front.sv
// Front stages: legs, squares, zone decision.
`default_nettype none
module ldva_front
  import ldva_pkg::*;
#(
  parameter int POS_WIDTH = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 v_in,
  input  wire logic [POS_WIDTH-1:0] src_x,
  input  wire logic [POS_WIDTH-1:0] src_y,
  input  wire logic [POS_WIDTH-1:0] lis_x,
  input  wire logic [POS_WIDTH-1:0] lis_y,
  input  wire logic [BASE_W-1:0]    base,
  input  wire logic [MULT_W-1:0]    mult,
  input  wire logic [RAD_W-1:0]     full,
  input  wire logic [RAD_W-1:0]     hear,
  output logic                      v_out,
  output logic [SQ_W-1:0]           s_out,
  output ldva_side_t                side_out
);

  localparam logic [33:0] LEG_CLAMP = 34'd1 << 25;

  logic signed [33:0] dx, dy;
  logic [33:0]        ax, ay;

  // stage 1
  logic               v1_r;
  logic [LEG_W-1:0]   lx_r, ly_r;
  logic [BASE_W-1:0]  base1_r;
  logic [MULT_W-1:0]  mult1_r;
  logic [RAD_W-1:0]   full1_r, hear1_r;
  // stage 2
  logic               v2_r;
  logic [2*LEG_W-1:0] sqx_r, sqy_r;
  logic [SQ_W-1:0]    hh_r, ff_r;
  logic [PEAK_W-1:0]  peak2_r;
  logic [RAD_W-1:0]   full2_r, hear2_r;
  // stage 3
  logic [2*LEG_W:0]   s_sum;
  logic               silent, near;
  logic [RAD_W-1:0]   scope;
  zone_t              zone_nxt;

  assign dx = 34'($signed(src_x)) - 34'($signed(lis_x));
  assign dy = 34'($signed(src_y)) - 34'($signed(lis_y));
  assign ax = dx[33] ? 34'(-dx) : 34'(dx);
  assign ay = dy[33] ? 34'(-dy) : 34'(dy);

  assign s_sum  = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign silent = s_sum > (2*LEG_W+1)'(hh_r);
  assign near   = s_sum < (2*LEG_W+1)'(ff_r);
  assign scope  = hear2_r - full2_r;

  always_comb begin
    priority if (silent) begin
      zone_nxt = ZONE_SILENT;
    end else if (near) begin
      zone_nxt = ZONE_FULL;
    end else if (scope == '0) begin
      zone_nxt = ZONE_ZERO;
    end else begin
      zone_nxt = ZONE_FALL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v1_r  <= v_in;
      v2_r  <= v1_r;
      v_out <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx_r    <= (ax > LEG_CLAMP) ? LEG_CLAMP[LEG_W-1:0] : ax[LEG_W-1:0];
      ly_r    <= (ay > LEG_CLAMP) ? LEG_CLAMP[LEG_W-1:0] : ay[LEG_W-1:0];
      base1_r <= base;
      mult1_r <= mult;
      full1_r <= full;
      hear1_r <= hear;

      sqx_r   <= (2*LEG_W)'(lx_r) * (2*LEG_W)'(lx_r);
      sqy_r   <= (2*LEG_W)'(ly_r) * (2*LEG_W)'(ly_r);
      hh_r    <= SQ_W'(hear1_r) * SQ_W'(hear1_r);
      ff_r    <= SQ_W'(full1_r) * SQ_W'(full1_r);
      peak2_r <= PEAK_W'(base1_r) * PEAK_W'(mult1_r);
      full2_r <= full1_r;
      hear2_r <= hear1_r;

      s_out          <= s_sum[SQ_W-1:0];
      side_out.zone  <= zone_nxt;
      side_out.peak  <= peak2_r;
      side_out.hear  <= hear2_r;
      side_out.scope <= scope;
    end
  end

endmodule
`default_nettype wire

### design/ldva_sqrt.sv
// Pipelined integer square root, two radicand bits per stage.
`default_nettype none
module ldva_sqrt
  import ldva_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire logic [SQ_W-1:0] s_in,
  input  ldva_side_t           side_in,
  output logic                 v_out,
  output logic [ROOT_W-1:0]    root_out,
  output ldva_side_t           side_out
);

  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              v_r    [0:STEPS];
  logic [SQ_W-1:0]   s_r    [0:STEPS];
  logic [REM_W-1:0]  rem_r  [0:STEPS];
  logic [ROOT_W-1:0] root_r [0:STEPS];
  ldva_side_t        side_r [0:STEPS];

  assign v_r[0]    = v_in;
  assign s_r[0]    = s_in;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign side_r[0] = side_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [REM_W-1:0] remx, trial;
    logic             take;

    assign remx  = {rem_r[i][REM_W-3:0], s_r[i][SQ_W-1-2*i -: 2]};
    assign trial = {root_r[i], 2'b01};
    assign take  = remx >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i+1]    <= s_r[i];
        side_r[i+1] <= side_r[i];
        rem_r[i+1]  <= take ? remx - trial : remx;
        root_r[i+1] <= {root_r[i][ROOT_W-2:0], take};
      end
    end
  end

  assign v_out    = v_r[STEPS];
  assign root_out = root_r[STEPS];
  assign side_out = side_r[STEPS];

endmodule
`default_nettype wire

### design/ldva_fall.sv
// Falloff scaling: peak times remaining distance, then pipelined divide by scope.
`default_nettype none
module ldva_fall
  import ldva_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              v_in,
  input  wire logic [ROOT_W-1:0] root,
  input  ldva_side_t             side_in,
  output logic                   v_out,
  output logic [VOL_W-1:0]       vol_out,
  output zone_t                  zone_out
);

  localparam int NUM_W = PROD_W - FRAC_SH;  // numerator after dropping fraction
  localparam int STEPS = VOL_W;             // quotient always fits the result

  logic [RAD_W-1:0]  rem_dist;
  logic              vm_r;
  logic [PROD_W-1:0] prod_r;
  ldva_side_t        sidem_r;

  assign rem_dist = side_in.hear - root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= PROD_W'(side_in.peak) * PROD_W'(rem_dist);
      sidem_r <= side_in;
    end
  end

  logic              v_r    [0:STEPS];
  logic [RAD_W-1:0]  r_r    [0:STEPS];
  logic [STEPS-1:0]  n_r    [0:STEPS];
  logic [STEPS-1:0]  q_r    [0:STEPS];
  ldva_side_t        side_r [0:STEPS];

  // numerator top bits are already below the divisor
  assign v_r[0]    = vm_r;
  assign r_r[0]    = prod_r[PROD_W-1 -: RAD_W];
  assign n_r[0]    = prod_r[FRAC_SH +: STEPS];
  assign q_r[0]    = '0;
  assign side_r[0] = sidem_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [RAD_W:0] rx;
    logic           take;

    assign rx   = {r_r[i], n_r[i][STEPS-1]};
    assign take = rx >= {1'b0, side_r[i].scope};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i+1] <= side_r[i];
        n_r[i+1]    <= {n_r[i][STEPS-2:0], 1'b0};
        q_r[i+1]    <= {q_r[i][STEPS-2:0], take};
        r_r[i+1]    <= take ? RAD_W'(rx - {1'b0, side_r[i].scope}) : rx[RAD_W-1:0];
      end
    end
  end

  logic [VOL_W-1:0] vol_nxt;

  always_comb begin
    unique case (side_r[STEPS].zone)
      ZONE_FULL: vol_nxt = side_r[STEPS].peak[PEAK_W-1:FRAC_SH];
      ZONE_FALL: vol_nxt = q_r[STEPS];
      default:   vol_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vol_out  <= vol_nxt;
      zone_out <= side_r[STEPS].zone;
    end
  end

  // NUM_W documents the divide span: top RAD_W bits plus STEPS shifted-in bits
  if (NUM_W != RAD_W + STEPS) begin : g_bad_width
    $error("divide width mismatch");
  end

endmodule
`default_nettype wire

### design/linear_distance_volume_attenuator_unit.sv
// Top level of the linear distance volume attenuator.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: source_x, source_y, base_volume,
//          |     |                      |   volume_multiplier, full_volume_radius,
//          |     |                      |   hearable_radius (low bits first)
//  out_    | out | out_tvalid/out_tready| out_tdata: spatial_volume; out_tuser: zone
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index (0 listener_x, 1 listener_y), cfg_data
//
// One request per cycle while the output is not stalled; a request passes the front,
// root, multiply, divide and output stages in order, one bit per stage in root and divide.
// rst_n is synchronous: it empties the pipe and clears the listener position.
// All stages advance together; the pipe holds whenever the output request
// waits, so in_tready drops only while out_tvalid is high and out_tready low.
// Config writes are always taken.
`default_nettype none
module linear_distance_volume_attenuator_unit
  import ldva_pkg::*;
#(
  parameter int POS_WIDTH = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request in
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // source_x, source_y, base_volume, volume_multiplier,
  // full_volume_radius, hearable_radius, zero pad
  input  wire logic [((2*POS_WIDTH+BASE_W+MULT_W+2*RAD_W+7)/8)*8-1:0] in_tdata,
  // result out
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_W-1:0]          out_tdata,   // spatial_volume, zero pad
  output logic [ZONE_W-1:0]         out_tuser,   // zone
  // listener config
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [POS_WIDTH-1:0] cfg_data
);

  localparam int SY_LO = POS_WIDTH;
  localparam int BV_LO = 2 * POS_WIDTH;
  localparam int VM_LO = BV_LO + BASE_W;
  localparam int FR_LO = VM_LO + MULT_W;
  localparam int HR_LO = FR_LO + RAD_W;

  logic [POS_WIDTH-1:0] lis_x_r, lis_y_r;
  logic                 en;

  // whole pipe advances unless a finished result is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lis_x_r <= '0;
      lis_y_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LIS_X: lis_x_r <= cfg_data;
        CFG_LIS_Y: lis_y_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  logic            f_v;
  logic [SQ_W-1:0] f_s;
  ldva_side_t      f_side;

  ldva_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (in_tvalid),
    .src_x    (in_tdata[POS_WIDTH-1:0]),
    .src_y    (in_tdata[SY_LO +: POS_WIDTH]),
    .lis_x    (lis_x_r),
    .lis_y    (lis_y_r),
    .base     (in_tdata[BV_LO +: BASE_W]),
    .mult     (in_tdata[VM_LO +: MULT_W]),
    .full     (in_tdata[FR_LO +: RAD_W]),
    .hear     (in_tdata[HR_LO +: RAD_W]),
    .v_out    (f_v),
    .s_out    (f_s),
    .side_out (f_side)
  );

  logic              r_v;
  logic [ROOT_W-1:0] r_root;
  ldva_side_t        r_side;

  ldva_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (f_v),
    .s_in     (f_s),
    .side_in  (f_side),
    .v_out    (r_v),
    .root_out (r_root),
    .side_out (r_side)
  );

  logic [VOL_W-1:0] vol;
  zone_t            zone;

  ldva_fall u_fall (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (r_v),
    .root     (r_root),
    .side_in  (r_side),
    .v_out    (out_tvalid),
    .vol_out  (vol),
    .zone_out (zone)
  );

  assign out_tdata = OUT_W'(vol);
  assign out_tuser = zone;

endmodule
`default_nettype wire

### design/ldva_check.sv
// Port-level checker for the attenuator, bound to the top level.
`default_nettype none
module ldva_check
  import ldva_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tready,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [OUT_W-1:0]     out_tdata,
  input wire logic [ZONE_W-1:0]    out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_mute: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ZONE_SILENT || out_tuser == ZONE_ZERO)
      |-> out_tdata == '0)
    else $error("silent or zero-scope result carries volume");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind linear_distance_volume_attenuator_unit ldva_check u_ldva_check (.*);
`default_nettype wire
